@@ rtl/bdi_pkg.sv @@
`default_nettype none

package bdi_pkg;

  localparam int LINE_BITS = 512;
  localparam int NUM_BD    = 6;

  // Encoding codes of the result
  localparam logic [3:0] ENC_ZERO = 4'd0;
  localparam logic [3:0] ENC_REP  = 4'd1;
  localparam logic [3:0] ENC_NONE = 4'd8;

  localparam logic [6:0] SIZE_ZERO = 7'd1;
  localparam logic [6:0] SIZE_REP  = 7'd8;
  localparam logic [6:0] SIZE_NONE = 7'd64;

  // Base-delta encodings in priority order
  localparam int         BD_ELEM_BITS  [NUM_BD] = '{64, 32, 64, 16, 32, 64};
  localparam int         BD_DELTA_BITS [NUM_BD] = '{8, 8, 16, 8, 16, 32};
  localparam logic [3:0] BD_CODE       [NUM_BD] = '{4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7};
  localparam logic [6:0] BD_SIZE       [NUM_BD] = '{7'd16, 7'd20, 7'd24, 7'd34, 7'd36, 7'd40};

  // word0 sits in the most significant bits, so the struct is the line, byte 0 first
  typedef struct packed {
    logic [63:0] word0;
    logic [63:0] word1;
    logic [63:0] word2;
    logic [63:0] word3;
    logic [63:0] word4;
    logic [63:0] word5;
    logic [63:0] word6;
    logic [63:0] word7;
  } line_t;

  typedef struct packed {
    logic [3:0]  encoding;
    logic [31:0] zero_mask;
    logic [6:0]  packed_bytes;
  } result_t;

  // v holds a w-bit element, zero-extended; true if it fits d bits signed
  function automatic logic fits_signed(logic [63:0] v, int unsigned w, int unsigned d);
    logic [63:0] ones;
    logic [63:0] top;
    ones = {64{1'b1}} >> (64 - w);
    top  = v >> (d - 1);
    return (top == '0) || (top == (ones >> (d - 1)));
  endfunction

endpackage

`default_nettype wire

@@ rtl/bdi_block_compressibility_check.sv @@
`default_nettype none

// Base-delta-immediate compressibility check. One 64-byte line enters per beat on
// the line channel (word0 holds bytes 0-7, byte 0 most significant) and one result
// leaves per beat on the result channel: the first encoding that fits, in the order
// zero, repeat, B8-D1, B4-D1, B8-D2, B2-D1, B4-D2, B8-D4, none, with its zero-base
// mask (element 0 in the highest used bit, 0 for zero, repeat and none) and its
// packed size in bytes. The block takes one line per clock while line_stall is low.
// There are four register stages: fit test of every element, base pick, delta test
// against the base, and the final priority select into the output register. The
// first stage loads at the accepting edge; valid then moves through v1, v2, v3 and
// result_valid. Each stage holds only while the stage after it is full and stalled,
// so bubbles close up and a stalled result does not block lines still in flight.

module bdi_block_compressibility_check import bdi_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    line_valid,
  output logic         line_stall,
  input  wire line_t   line,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  // Stage valids and ready chain
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;

  // Stage 1: line, zero-base fit masks, whole-line flags
  logic [LINE_BITS-1:0] line1;
  logic [31:0]          fit1 [NUM_BD];
  logic                 zero1, same1;
  // Stage 2: base per encoding
  logic [LINE_BITS-1:0] line2;
  logic [31:0]          fit2 [NUM_BD];
  logic [63:0]          base2 [NUM_BD];
  logic                 zero2, same2;
  // Stage 3: pass per encoding
  logic [31:0]          fit3 [NUM_BD];
  logic [NUM_BD-1:0]    pass3;
  logic                 zero3, same3;

  // Combinational results feeding each stage
  logic [31:0]          fit_d  [NUM_BD];
  logic [63:0]          base_d [NUM_BD];
  logic [NUM_BD-1:0]    pass_d;
  logic                 zero_d, same_d;
  result_t              result_d;

  // A stage may load when it is empty or its content moves on this cycle
  assign rdy4 = !result_valid || !result_stall;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign line_stall = !rdy1;

  assign zero_d = (line == '0);
  assign same_d = (line.word1 == line.word0) && (line.word2 == line.word0) &&
                  (line.word3 == line.word0) && (line.word4 == line.word0) &&
                  (line.word5 == line.word0) && (line.word6 == line.word0) &&
                  (line.word7 == line.word0);

  for (genvar c = 0; c < NUM_BD; c++) begin : g_bd
    localparam int          W     = BD_ELEM_BITS[c];
    localparam int          N     = LINE_BITS / W;
    localparam int          D     = BD_DELTA_BITS[c];
    localparam logic [63:0] WMASK = {64{1'b1}} >> (64 - W);

    logic [31:0] fit_c;
    logic [31:0] nf_e;
    logic [31:0] pick;
    logic [63:0] base_c;
    logic        pass_c;

    // Test every element against the zero base; element i lands at bit N-1-i
    always_comb begin
      fit_c = '0;
      for (int i = 0; i < N; i++) begin
        fit_c[N-1-i] = fits_signed(64'(line[LINE_BITS-1-i*W -: W]), W, D);
      end
    end

    // Pick the first element that misses the zero base; isolate lowest set bit
    always_comb begin
      nf_e = '0;
      for (int i = 0; i < N; i++) begin
        nf_e[i] = !fit1[c][N-1-i];
      end
      pick   = nf_e & (~nf_e + 32'd1);
      base_c = '0;
      for (int i = 0; i < N; i++) begin
        base_c = base_c | (pick[i] ? 64'(line1[LINE_BITS-1-i*W -: W]) : 64'd0);
      end
    end

    // Every element off the zero base must fit as a wrapped delta from the base
    always_comb begin
      logic [63:0] diff;
      pass_c = 1'b1;
      for (int i = 0; i < N; i++) begin
        diff = (64'(line2[LINE_BITS-1-i*W -: W]) - base2[c]) & WMASK;
        if (!fit2[c][N-1-i] && !fits_signed(diff, W, D)) begin
          pass_c = 1'b0;
        end
      end
    end

    assign fit_d[c]  = fit_c;
    assign base_d[c] = base_c;
    assign pass_d[c] = pass_c;
  end

  // Priority select: walk from lowest priority up so the first fit wins
  always_comb begin
    result_d.encoding     = ENC_NONE;
    result_d.zero_mask    = '0;
    result_d.packed_bytes = SIZE_NONE;
    for (int c = NUM_BD - 1; c >= 0; c--) begin
      if (pass3[c]) begin
        result_d.encoding     = BD_CODE[c];
        result_d.zero_mask    = fit3[c];
        result_d.packed_bytes = BD_SIZE[c];
      end
    end
    if (same3) begin
      result_d.encoding     = ENC_REP;
      result_d.zero_mask    = '0;
      result_d.packed_bytes = SIZE_REP;
    end
    if (zero3) begin
      result_d.encoding     = ENC_ZERO;
      result_d.zero_mask    = '0;
      result_d.packed_bytes = SIZE_ZERO;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= line_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) result_valid <= v3;
    end
  end

  // Payload: advance each stage when it may load, hold otherwise
  always_ff @(posedge clk) begin
    if (rdy1) begin
      line1 <= line;
      zero1 <= zero_d;
      same1 <= same_d;
      for (int c = 0; c < NUM_BD; c++) fit1[c] <= fit_d[c];
    end
    if (rdy2) begin
      line2 <= line1;
      zero2 <= zero1;
      same2 <= same1;
      for (int c = 0; c < NUM_BD; c++) begin
        fit2[c]  <= fit1[c];
        base2[c] <= base_d[c];
      end
    end
    if (rdy3) begin
      pass3 <= pass_d;
      zero3 <= zero2;
      same3 <= same2;
      for (int c = 0; c < NUM_BD; c++) fit3[c] <= fit2[c];
    end
    if (rdy4) begin
      result <= result_d;
    end
  end

  // Stall the line channel only when every stage holds a line
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    line_stall |-> (v1 && v2 && v3 && result_valid))
    else $error("line channel stalled with a bubble in the pipeline");

  // A line in the last inner stage must not vanish while the output holds
  a_hold_v3: assert property (@(posedge clk) disable iff (rst)
    (v3 && result_valid && result_stall) |=> v3)
    else $error("stage 3 dropped a line under output stall");

  // No mask without a base-delta encoding
  a_mask_meaning: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.encoding == ENC_ZERO || result.encoding == ENC_REP ||
                      result.encoding == ENC_NONE)) |-> (result.zero_mask == '0))
    else $error("zero_mask set for an encoding without a base");

  // Size follows the encoding for the fixed cases
  a_size_none: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.encoding == ENC_NONE) |-> (result.packed_bytes == SIZE_NONE))
    else $error("uncompressed line with wrong size");

endmodule

`default_nettype wire

@@ tb/bdi_block_compressibility_check_test.sv @@
`default_nettype none

module bdi_block_compressibility_check_test;
  import bdi_pkg::*;

  // Base-delta codes; zero, repeat and none come from the package
  localparam logic [3:0] ENC_B8D1 = 4'd2;
  localparam logic [3:0] ENC_B4D1 = 4'd3;
  localparam logic [3:0] ENC_B8D2 = 4'd4;
  localparam logic [3:0] ENC_B2D1 = 4'd5;
  localparam logic [3:0] ENC_B4D2 = 4'd6;
  localparam logic [3:0] ENC_B8D4 = 4'd7;
  localparam int NUM_SCHEMES = 6;

  // Four register stages between an accepted line and result_valid
  localparam int PIPE_DEPTH = 4;

  logic    clk;
  logic    rst;
  logic    line_valid;
  logic    line_stall;
  line_t   line;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  // Encodings predicted for accepted lines, oldest first
  result_t pending_encodings[$];
  int      mismatch_count = 0;
  int      results_seen   = 0;

  // Idle controls shared by the sender, the receiver and the tests
  bit      sender_idle   = 1'b0;
  bit      receiver_idle = 1'b0;
  int      hold_left     = 0;

  bdi_block_compressibility_check i_dut (
    .clk          (clk),
    .rst          (rst),
    .line_valid   (line_valid),
    .line_stall   (line_stall),
    .line         (line),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Encoding predictor
  // ---------------------------------------------------------------------------

  // Scheme k in priority order: B8D1, B4D1, B8D2, B2D1, B4D2, B8D4
  function automatic int scheme_elem_w(int k);
    case (k)
      0, 2, 5: return 64;
      1, 4:    return 32;
      default: return 16;
    endcase
  endfunction

  function automatic int scheme_delta_w(int k);
    case (k)
      0, 1, 3: return 8;
      2, 4:    return 16;
      default: return 32;
    endcase
  endfunction

  function automatic logic [3:0] scheme_code(int k);
    case (k)
      0:       return ENC_B8D1;
      1:       return ENC_B4D1;
      2:       return ENC_B8D2;
      3:       return ENC_B2D1;
      4:       return ENC_B4D2;
      default: return ENC_B8D4;
    endcase
  endfunction

  function automatic logic [6:0] scheme_bytes(int k);
    case (k)
      0:       return 7'd16;
      1:       return 7'd20;
      2:       return 7'd24;
      3:       return 7'd34;
      4:       return 7'd36;
      default: return 7'd40;
    endcase
  endfunction

  function automatic logic [63:0] elem_mask(int ebits);
    return (ebits == 64) ? {64{1'b1}} : ((64'd1 << ebits) - 64'd1);
  endfunction

  // v is an element of the width in wmask; read it signed and test the delta range
  function automatic bit fits_delta(logic [63:0] v, logic [63:0] wmask, int dbits);
    logic [63:0] half;
    half = 64'd1 << (dbits - 1);
    return ((v + half) & wmask) < (64'd1 << dbits);
  endfunction

  function automatic result_t classify_line(line_t ln);
    logic [511:0] bits;
    logic [63:0]  first;
    logic [63:0]  wj;
    logic [63:0]  v;
    logic [63:0]  base;
    logic [63:0]  wmask;
    logic [31:0]  mask;
    bit           all_zero;
    bit           all_same;
    bit           have_base;
    bit           deltas_fit;
    int           ebits;
    int           dbits;
    int           n;
    result_t      r;

    bits     = ln;
    first    = bits[511 -: 64];
    all_zero = 1'b1;
    all_same = 1'b1;
    for (int j = 0; j < 8; j++) begin
      wj = bits[511 - 64 * j -: 64];
      if (wj != 64'd0) all_zero = 1'b0;
      if (wj != first) all_same = 1'b0;
    end

    r = '0;
    if (all_zero) begin
      r.encoding     = ENC_ZERO;
      r.packed_bytes = SIZE_ZERO;
      return r;
    end
    if (all_same) begin
      r.encoding     = ENC_REP;
      r.packed_bytes = SIZE_REP;
      return r;
    end

    for (int k = 0; k < NUM_SCHEMES; k++) begin
      ebits      = scheme_elem_w(k);
      dbits      = scheme_delta_w(k);
      wmask      = elem_mask(ebits);
      n          = 512 / ebits;
      mask       = '0;
      base       = '0;
      have_base  = 1'b0;
      deltas_fit = 1'b1;
      // Element 0 is the most significant slice of the line
      for (int i = 0; i < n; i++) begin
        v = 64'(bits >> (512 - (i + 1) * ebits)) & wmask;
        if (fits_delta(v, wmask, dbits)) begin
          mask[n - 1 - i] = 1'b1;
        end else if (!have_base) begin
          base      = v;
          have_base = 1'b1;
        end
      end
      for (int i = 0; i < n; i++) begin
        if (!mask[n - 1 - i]) begin
          v = 64'(bits >> (512 - (i + 1) * ebits)) & wmask;
          if (!fits_delta((v - base) & wmask, wmask, dbits)) deltas_fit = 1'b0;
        end
      end
      if (deltas_fit) begin
        r.encoding     = scheme_code(k);
        r.zero_mask    = mask;
        r.packed_bytes = scheme_bytes(k);
        return r;
      end
    end

    r.encoding     = ENC_NONE;
    r.packed_bytes = SIZE_NONE;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Line generators
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int idle_length();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 10) return 0;
    if (pick < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Signed delta in dbits, sign-extended to 64; lean on the range edges, and
  // step just past them when a miss is wanted
  function automatic logic [63:0] near_delta(int dbits, bit miss);
    logic [63:0] half;
    int          pick;
    half = 64'd1 << (dbits - 1);
    if (miss) return $urandom_range(0, 1) ? half : (-half - 64'd1);
    pick = $urandom_range(0, 9);
    if (pick == 0) return -half;
    if (pick == 1) return half - 64'd1;
    return ({32'd0, $urandom} & ((half << 1) - 64'd1)) - half;
  endfunction

  // Line aimed at scheme k: a mix of zero-base and arbitrary-base elements,
  // with an occasional out-of-range delta or wild element when broken is set
  function automatic line_t shaped_line(int k, bit broken);
    logic [511:0] bits;
    logic [63:0]  wmask;
    logic [63:0]  base;
    logic [63:0]  elem;
    int           ebits;
    int           dbits;
    int           n;
    int           wild;
    bit           miss;

    ebits = scheme_elem_w(k);
    dbits = scheme_delta_w(k);
    wmask = elem_mask(ebits);
    n     = 512 / ebits;
    base  = random_word() & wmask;
    wild  = (broken && $urandom_range(0, 1) == 0) ? $urandom_range(0, n - 1) : -1;
    bits  = '0;
    for (int i = 0; i < n; i++) begin
      miss = broken && ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 3) == 0) elem = near_delta(dbits, miss);
      else elem = base + near_delta(dbits, miss);
      if (i == wild) elem = random_word();
      bits = (bits << ebits) | (elem & wmask);
    end
    return line_t'(bits);
  endfunction

  function automatic line_t random_line();
    logic [511:0] bits;
    logic [63:0]  w;
    int           pick;

    bits = '0;
    pick = $urandom_range(0, 19);
    case (pick)
      0: return '0;
      1: begin
        w = random_word();
        return line_t'({8{w}});
      end
      2, 3: begin
        for (int j = 0; j < 8; j++) bits = (bits << 64) | random_word();
      end
      4: begin
        // Words of mixed magnitude and sign
        for (int j = 0; j < 8; j++) begin
          w = random_word() >> $urandom_range(0, 63);
          if ($urandom_range(0, 1)) w = ~w;
          bits = (bits << 64) | w;
        end
      end
      default: return shaped_line($urandom_range(0, NUM_SCHEMES - 1), $urandom_range(0, 3) == 0);
    endcase
    return line_t'(bits);
  endfunction

  // ---------------------------------------------------------------------------
  // Line channel driver
  // ---------------------------------------------------------------------------

  // Drive one line beat at the falling edge, hold it until the block takes it,
  // and queue its predicted encoding. Valid stays high after the beat so that
  // back-to-back lines never drop it inside one step.
  task automatic send_line(input line_t ln);
    int gap;
    gap = sender_idle ? idle_length() : 0;
    @(negedge clk);
    if (gap > 0) begin
      line_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    line       <= ln;
    line_valid <= 1'b1;
    // Stall read right after the edge is the value the block saw at that edge
    do @(posedge clk); while (line_stall);
    pending_encodings.push_back(classify_line(ln));
  endtask

  // ---------------------------------------------------------------------------
  // Result channel: stall pattern and checker
  // ---------------------------------------------------------------------------

  // Receiver: a requested hold-off wins, then any running stall, then random
  // stalls when idling is on; exactly one stall update per falling edge
  initial begin
    int stall_run;
    stall_run    = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else if (stall_run > 0) begin
        result_stall <= 1'b1;
        stall_run--;
      end else if (receiver_idle && $urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        stall_run = idle_length();
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] result %0d: %s got %0h, want %0h", $time, results_seen, what, got, want);
    mismatch_count++;
  endtask

  // Compare every result beat with the oldest prediction
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_encodings.size() == 0) begin
        report_mismatch("result with no line pending, encoding", 64'(result.encoding), '0);
      end else begin
        want = pending_encodings.pop_front();
        if (result.encoding !== want.encoding)
          report_mismatch("encoding", 64'(result.encoding), 64'(want.encoding));
        if (result.zero_mask !== want.zero_mask)
          report_mismatch("zero_mask", 64'(result.zero_mask), 64'(want.zero_mask));
        if (result.packed_bytes !== want.packed_bytes)
          report_mismatch("packed_bytes", 64'(result.packed_bytes),
                          64'(want.packed_bytes));
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // All-zero and repeated-word lines, including all ones and the sign bit alone
  task automatic test_uniform_lines();
    send_line('0);
    send_line({8{64'hFFFF_FFFF_FFFF_FFFF}});
    send_line({8{64'h8000_0000_0000_0000}});
    send_line({8{64'h0123_4567_89AB_CDEF}});
  endtask

  // Each base-delta scheme twice, then two lines that fit nothing
  task automatic test_each_encoding();
    for (int k = 0; k < NUM_SCHEMES; k++) begin
      send_line(shaped_line(k, 1'b0));
      send_line(shaped_line(k, 1'b0));
    end
    send_line({64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
               64'h0F1E_2D3C_4B5A_6978, 64'h8796_A5B4_C3D2_E1F0,
               64'h1357_9BDF_0246_8ACE, 64'hECA8_6420_FDB9_7531,
               64'h7F00_FF00_00FF_00FF, 64'h00FF_7F00_FF00_FF80});
    send_line({4{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555}});
  endtask

  // Delta range edges, a line with no arbitrary base, and wrapped differences
  task automatic test_delta_edges();
    // Every element fits the zero base: full mask
    send_line({64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd6, 64'd7, 64'd8});
    // Base at the top of the signed range; differences wrap around 2^64
    send_line({64'hFFFF_FFFF_FFFF_FF80, 64'h0000_0000_0000_007F,
               64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
               64'h7FFF_FFFF_FFFF_FF80, 64'h0000_0000_0000_0000,
               64'h8000_0000_0000_007E, 64'h7FFF_FFFF_FFFF_FF7F});
    // Deltas exactly at -128 and +127 from the base
    send_line({64'h4000_0000_0000_0000, 64'h3FFF_FFFF_FFFF_FF80,
               64'h4000_0000_0000_007F, 64'hFFFF_FFFF_FFFF_FF80,
               64'h0000_0000_0000_007F, 64'h4000_0000_0000_0000,
               64'h4000_0000_0000_0001, 64'h0000_0000_0000_0000});
    // One delta just past +127: falls to a wider scheme
    send_line({64'h4000_0000_0000_0000, 64'h4000_0000_0000_0080,
               64'h4000_0000_0000_0001, 64'h0000_0000_0000_0000,
               64'h4000_0000_0000_0000, 64'h4000_0000_0000_0002,
               64'h4000_0000_0000_0003, 64'h4000_0000_0000_0004});
  endtask

  // Random lines with idling on both sides
  task automatic test_random_lines();
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    repeat (300) send_line(random_line());
  endtask

  // A stretch with no idling at all: one line per clock while the block takes them
  task automatic test_back_to_back();
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    repeat (60) send_line(random_line());
  endtask

  // Hold off the result side for a long stretch while lines keep coming, so
  // the pipeline fills and the block stalls the line side
  task automatic test_result_hold_off();
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    hold_left     = 300;
    repeat (40) send_line(random_line());
    receiver_idle = 1'b1;
  endtask

  initial begin
    rst        = 1'b1;
    line_valid = 1'b0;
    line       = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_uniform_lines();
    test_each_encoding();
    test_delta_edges();
    test_random_lines();
    test_back_to_back();
    test_result_hold_off();

    // Drop valid, drain every outstanding result, then let the pipeline run dry
    @(negedge clk);
    line_valid <= 1'b0;
    while (pending_encodings.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH * 4) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
